// ===== design/zero_cross_mains_tracker_macros.svh =====
// ----------------------------------------------------------------------------
// zero_cross_mains_tracker_macros.svh
// Assertion macros for the zero-cross mains tracker RTL.
// ----------------------------------------------------------------------------
`ifndef ZERO_CROSS_MAINS_TRACKER_MACROS_SVH
`define ZERO_CROSS_MAINS_TRACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ZCMT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ZCMT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/zcmt_pkg.sv =====
// ----------------------------------------------------------------------------
// zcmt_pkg
// Types and constants for the zero-cross mains tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package zcmt_pkg;

    localparam int TIME_W    = 32;
    localparam int HALF_W    = 16;
    localparam int REC_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int TMO_W     = 26;

    localparam logic [TMO_W-1:0] US_PER_MS     = TMO_W'(1000);
    localparam int               HALF_50_US    = 10000;
    localparam int               HALF_60_US    = 8333;
    localparam logic [TIME_W-1:0] FREQ_SPLIT_US = TIME_W'((HALF_50_US + HALF_60_US) / 2);

    localparam logic [CFG_IDX_W-1:0] REG_MIN_HALF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HALF  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GLITCH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVERY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_ON   = 3'd5;

    localparam logic [HALF_W-1:0] RST_MIN_HALF   = 16'd7000;
    localparam logic [HALF_W-1:0] RST_MAX_HALF   = 16'd12000;
    localparam logic [HALF_W-1:0] RST_GLITCH     = 16'd0;
    localparam logic [REC_W-1:0]  RST_RECOVERY   = 8'd3;
    localparam logic [TMO_W-1:0]  RST_TIMEOUT_US = TMO_W'(100 * 1000);

    typedef enum logic [1:0] {
        CMD_EDGE  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_WAITING   = 2'd0,
        ST_ALIVE     = 2'd1,
        ST_LOST      = 2'd2,
        ST_CFG_ERROR = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FREQ_UNKNOWN = 2'd0,
        FREQ_50      = 2'd1,
        FREQ_60      = 2'd2
    } freq_t;

    typedef struct packed {
        logic [HALF_W-1:0] min_half;
        logic [HALF_W-1:0] max_half;
        logic [HALF_W-1:0] glitch;
        logic [REC_W-1:0]  recovery;
        logic [TMO_W-1:0]  timeout_us;
        logic              freq_on;
        logic              ok;
    } cfg_t;

    typedef struct packed {
        logic              event_valid;
        logic [TIME_W-1:0] event_time;
        logic [HALF_W-1:0] interval_us;
        logic [TIME_W-1:0] sequence_num;
        logic [1:0]        freq;
        logic [1:0]        status;
        logic              alive;
    } result_t;

endpackage

`default_nettype wire

// ===== design/zcmt_cfg.sv =====
// ----------------------------------------------------------------------------
// zcmt_cfg
// Configuration register file with validity check and timeout scaling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zcmt_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [zcmt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [zcmt_pkg::CFG_DAT_W-1:0] cfg_data,
    output zcmt_pkg::cfg_t                     cfg,
    output logic                               clear
);
    import zcmt_pkg::*;

    logic [HALF_W-1:0] min_half_reg;
    logic [HALF_W-1:0] max_half_reg;
    logic [HALF_W-1:0] glitch_reg;
    logic [REC_W-1:0]  recovery_reg;
    logic [TMO_W-1:0]  timeout_us_reg;
    logic              freq_on_reg;
    logic              wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    // The timeout is kept in microseconds so the tick path needs no multiplier.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_half_reg   <= RST_MIN_HALF;
            max_half_reg   <= RST_MAX_HALF;
            glitch_reg     <= RST_GLITCH;
            recovery_reg   <= RST_RECOVERY;
            timeout_us_reg <= RST_TIMEOUT_US;
            freq_on_reg    <= 1'b1;
        end
        else if (wr)
        begin
            case (cfg_index)
                REG_MIN_HALF: min_half_reg   <= cfg_data;
                REG_MAX_HALF: max_half_reg   <= cfg_data;
                REG_GLITCH:   glitch_reg     <= cfg_data;
                REG_RECOVERY: recovery_reg   <= cfg_data[REC_W-1:0];
                REG_TIMEOUT:  timeout_us_reg <= TMO_W'(cfg_data) * US_PER_MS;
                REG_FREQ_ON:  freq_on_reg    <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        clear = wr && (cfg_index <= REG_FREQ_ON);
        cfg.min_half   = min_half_reg;
        cfg.max_half   = max_half_reg;
        cfg.glitch     = glitch_reg;
        cfg.recovery   = recovery_reg;
        cfg.timeout_us = timeout_us_reg;
        cfg.freq_on    = freq_on_reg;
        cfg.ok         = (recovery_reg != '0) && (min_half_reg < max_half_reg);
    end

endmodule

`default_nettype wire

// ===== design/zcmt_engine.sv =====
// ----------------------------------------------------------------------------
// zcmt_engine
// Tracking state and per-item update for edge, tick and clear commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zcmt_engine (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  zcmt_pkg::cfg_t                  cfg,
    input  wire logic                       clear,
    input  wire logic                       step,
    input  wire logic [1:0]                 cmd,
    input  wire logic [zcmt_pkg::TIME_W-1:0] now_time,
    output zcmt_pkg::result_t               res
);
    import zcmt_pkg::*;

    logic [TIME_W-1:0] last_reg,   last_next;
    logic [HALF_W-1:0] half_reg,   half_next;
    logic [TIME_W-1:0] count_reg,  count_next;
    logic [1:0]        freq_reg,   freq_next;
    logic [REC_W-1:0]  prog_reg,   prog_next;
    logic [1:0]        status_reg, status_next;

    logic [TIME_W-1:0] span;
    logic              armed;
    logic              evt;

    always_comb
    begin
        span        = now_time - last_reg;
        armed       = (last_reg != '0);
        last_next   = last_reg;
        half_next   = half_reg;
        count_next  = count_reg;
        freq_next   = freq_reg;
        prog_next   = prog_reg;
        status_next = status_reg;
        evt         = 1'b0;

        case (cmd)
            CMD_EDGE:
            begin
                if ((cfg.glitch != '0) && armed && (span < TIME_W'(cfg.glitch)))
                begin
                    // Too close to the last edge: treated as a glitch.
                end
                else if (!armed)
                begin
                    last_next   = now_time;
                    status_next = ST_WAITING;
                end
                else if ((span >= TIME_W'(cfg.min_half)) && (span <= TIME_W'(cfg.max_half)))
                begin
                    last_next  = now_time;
                    half_next  = span[HALF_W-1:0];
                    count_next = count_reg + 1'b1;
                    if (cfg.freq_on)
                    begin
                        freq_next = (span >= FREQ_SPLIT_US) ? FREQ_50 : FREQ_60;
                    end
                    if (status_reg == ST_LOST)
                    begin
                        prog_next = prog_reg + 1'b1;
                        if (prog_next >= cfg.recovery)
                        begin
                            prog_next   = '0;
                            status_next = ST_ALIVE;
                            evt         = 1'b1;
                        end
                    end
                    else
                    begin
                        status_next = ST_ALIVE;
                        evt         = 1'b1;
                    end
                end
            end
            CMD_TICK:
            begin
                if ((cfg.timeout_us != '0) && armed && (status_reg == ST_ALIVE)
                    && (span > TIME_W'(cfg.timeout_us)))
                begin
                    status_next = ST_LOST;
                    prog_next   = '0;
                end
            end
            CMD_CLEAR:
            begin
                last_next   = '0;
                half_next   = '0;
                count_next  = '0;
                freq_next   = FREQ_UNKNOWN;
                prog_next   = '0;
                status_next = ST_WAITING;
            end
            default: ;
        endcase

        // With a bad configuration every command is ignored.
        if (!cfg.ok)
        begin
            res = '0;
            res.status = ST_CFG_ERROR;
        end
        else
        begin
            res.event_valid  = evt;
            res.event_time   = evt ? now_time : '0;
            res.interval_us  = half_next;
            res.sequence_num = count_next;
            res.freq         = freq_next;
            res.status       = status_next;
            res.alive        = (status_next == ST_ALIVE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg   <= '0;
            half_reg   <= '0;
            count_reg  <= '0;
            freq_reg   <= FREQ_UNKNOWN;
            prog_reg   <= '0;
            status_reg <= ST_WAITING;
        end
        else if (clear)
        begin
            last_reg   <= '0;
            half_reg   <= '0;
            count_reg  <= '0;
            freq_reg   <= FREQ_UNKNOWN;
            prog_reg   <= '0;
            status_reg <= ST_WAITING;
        end
        else if (step && cfg.ok)
        begin
            last_reg   <= last_next;
            half_reg   <= half_next;
            count_reg  <= count_next;
            freq_reg   <= freq_next;
            prog_reg   <= prog_next;
            status_reg <= status_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/zero_cross_mains_tracker.sv =====
// ----------------------------------------------------------------------------
// zero_cross_mains_tracker
// Mains zero-crossing tracker: edge interval check, frequency sort and loss
// detection, one result item for every input item.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Payload
//   --------  ---------------------  ---------------------------------------
//   input     in_valid / in_stall    cmd, now_time
//   output    out_valid / out_stall  event_valid, event_time, event_half_cycle,
//                                    event_sequence, frequency_class,
//                                    status_code, alive
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item passes from acceptance through the input register and then
// through the tracking update into the result register.
// A new item is accepted every cycle while the output is not stalled; the
// state update handles one item per clock.
// Reset (rst_n, asynchronous) restores the register defaults and clears the
// tracking state; a write to a defined register (index 0 to 5) clears it too.
// A stall on the output holds the result register, which then holds the
// input register and raises in_stall once both are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zero_cross_mains_tracker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [1:0]                     cmd,
    input  wire logic [zcmt_pkg::TIME_W-1:0]    now_time,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic                                event_valid,
    output logic [zcmt_pkg::TIME_W-1:0]         event_time,
    output logic [zcmt_pkg::HALF_W-1:0]         event_half_cycle,
    output logic [zcmt_pkg::TIME_W-1:0]         event_sequence,
    output logic [1:0]                          frequency_class,
    output logic [1:0]                          status_code,
    output logic                                alive,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [zcmt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [zcmt_pkg::CFG_DAT_W-1:0] cfg_data
);
    import zcmt_pkg::*;
    `include "zero_cross_mains_tracker_macros.svh"

    cfg_t              cfg;
    logic              clear;
    result_t           res;

    // Input register.
    logic              s1_valid_reg;
    logic [1:0]        s1_cmd_reg;
    logic [TIME_W-1:0] s1_now_reg;

    // Result register.
    logic              out_valid_reg;
    result_t           out_res_reg;

    logic              out_adv;
    logic              step;

    zcmt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .clear     (clear)
    );

    zcmt_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .clear    (clear),
        .step     (step),
        .cmd      (s1_cmd_reg),
        .now_time (s1_now_reg),
        .res      (res)
    );

    // The result register moves whenever it is empty or being taken; the
    // engine commits its state update in exactly the cycle its item moves on.
    assign out_adv  = !out_valid_reg || !out_stall;
    assign step     = s1_valid_reg && out_adv;
    assign in_stall = s1_valid_reg && !out_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_cmd_reg <= cmd;
            s1_now_reg <= now_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid        = out_valid_reg;
    assign event_valid      = out_res_reg.event_valid;
    assign event_time       = out_res_reg.event_time;
    assign event_half_cycle = out_res_reg.interval_us;
    assign event_sequence   = out_res_reg.sequence_num;
    assign frequency_class  = out_res_reg.freq;
    assign status_code      = out_res_reg.status;
    assign alive            = out_res_reg.alive;

    // An item that enters the input register is always held there next cycle.
    `ZCMT_ASSERT_NEXT(a_in_reg_loads, in_valid && !in_stall, s1_valid_reg, "input item lost")
    // An event is only reported while the tracker is alive.
    `ZCMT_ASSERT_IMPL(a_event_alive, out_valid && event_valid, alive && (status_code == ST_ALIVE), "event outside alive state")
    // Non-event results carry a zero timestamp.
    `ZCMT_ASSERT_IMPL(a_time_zero, out_valid && !event_valid, event_time == '0, "timestamp on non-event")
    // A configuration error reports a cleared result.
    `ZCMT_ASSERT_IMPL(a_cfg_err_clear, out_valid && (status_code == ST_CFG_ERROR), !event_valid && (event_sequence == '0) && (frequency_class == FREQ_UNKNOWN), "config error result not cleared")

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the zero-cross mains tracker. Items go in through
// the valid/stall input channel and results come back, one per item, through
// the output channel. A behavioral copy of the tracker, kept in step with
// every accepted item and every register write, works out the result that
// each item must produce. A checker compares the results field by field in
// arrival order. Directed items cover the interval window, the frequency
// split, time zero, wrap-around and loss recovery. Random traffic then runs
// under a sweep of register settings, including the extremes and invalid
// ones, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import zcmt_pkg::*;

    // The command encoding leaves one value unused; the block must ignore it.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam int STALL_MAX      = 11;
    localparam int IDLE_LIMIT     = 2000;
    localparam int RESULT_LATENCY = 2;
    localparam int MAX_PRINTED    = 40;
    localparam int HOLDOFF_CYCLES = 150;
    localparam int SWEEP_PHASES   = 12;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           cmd;
    logic [TIME_W-1:0]    now_time;
    logic                 out_valid;
    logic                 out_stall;
    logic                 event_valid;
    logic [TIME_W-1:0]    event_time;
    logic [HALF_W-1:0]    event_half_cycle;
    logic [TIME_W-1:0]    event_sequence;
    logic [1:0]           frequency_class;
    logic [1:0]           status_code;
    logic                 alive;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    zero_cross_mains_tracker uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .now_time         (now_time),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .event_valid      (event_valid),
        .event_time       (event_time),
        .event_half_cycle (event_half_cycle),
        .event_sequence   (event_sequence),
        .frequency_class  (frequency_class),
        .status_code      (status_code),
        .alive            (alive),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // Register copy used by the predictor.
    logic [HALF_W-1:0] cfg_min_half;
    logic [HALF_W-1:0] cfg_max_half;
    logic [HALF_W-1:0] cfg_glitch;
    logic [REC_W-1:0]  cfg_recovery;
    logic [15:0]       cfg_timeout_ms;
    logic              cfg_freq_on;

    // Tracking state of the predictor.
    logic [TIME_W-1:0] prev_edge_stamp;
    logic [HALF_W-1:0] held_half_us;
    logic [TIME_W-1:0] edge_total;
    freq_t             mains_class;
    logic [REC_W-1:0]  regain_tally;
    status_t           tracker_status;

    // Results owed by the block, oldest first.
    result_t tracker_reports[$];

    // Idling controls: the sender gap and the receiver stall drawn per item.
    int in_gap_max      = 0;
    int out_stall_max   = 0;
    int stall_left      = 0;
    int holdoff_request = 0;

    int error_count    = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int event_total    = 0;
    int loss_total     = 0;
    int settings_used  = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void restart_tracking();
        prev_edge_stamp = '0;
        held_half_us    = '0;
        edge_total      = '0;
        mains_class     = FREQ_UNKNOWN;
        regain_tally    = '0;
        tracker_status  = ST_WAITING;
    endfunction

    // Advances the tracking state by one item and returns the result it owes.
    function automatic result_t next_tracker_result(input logic [1:0] op,
                                                    input logic [TIME_W-1:0] now);
        result_t           r;
        logic [TIME_W-1:0] span;
        logic              fired;
        r     = '0;
        fired = 1'b0;
        span  = now - prev_edge_stamp;
        // An invalid register set freezes the tracker and reports only the error.
        if (cfg_recovery == 0 || cfg_min_half >= cfg_max_half) begin
            r.status = ST_CFG_ERROR;
            return r;
        end
        case (op)
            CMD_EDGE: begin
                // A glitch is only possible once armed; it leaves every state alone.
                if (!(cfg_glitch != 0 && prev_edge_stamp != 0 && span < cfg_glitch)) begin
                    if (prev_edge_stamp == 0) begin
                        // Unarmed: this edge only arms, and an edge at zero does not.
                        prev_edge_stamp = now;
                        tracker_status  = ST_WAITING;
                    end else if (span >= cfg_min_half && span <= cfg_max_half) begin
                        prev_edge_stamp = now;
                        held_half_us    = span[HALF_W-1:0];
                        edge_total      = edge_total + 1;
                        if (cfg_freq_on)
                            mains_class = (span >= FREQ_SPLIT_US) ? FREQ_50 : FREQ_60;
                        if (tracker_status == ST_LOST) begin
                            regain_tally = regain_tally + 1'b1;
                            if (regain_tally >= cfg_recovery) begin
                                regain_tally   = '0;
                                tracker_status = ST_ALIVE;
                                fired          = 1'b1;
                            end
                        end else begin
                            tracker_status = ST_ALIVE;
                            fired          = 1'b1;
                        end
                    end
                end
            end
            CMD_TICK: begin
                if (cfg_timeout_ms != 0 && prev_edge_stamp != 0 && tracker_status == ST_ALIVE
                    && span > 32'(cfg_timeout_ms) * 32'(US_PER_MS)) begin
                    tracker_status = ST_LOST;
                    regain_tally   = '0;
                    loss_total++;
                end
            end
            CMD_CLEAR: restart_tracking();
            default: ;
        endcase
        if (fired)
            event_total++;
        r.event_valid  = fired;
        r.event_time   = fired ? now : '0;
        r.interval_us  = held_half_us;
        r.sequence_num = edge_total;
        r.freq         = mains_class;
        r.status       = tracker_status;
        r.alive        = (tracker_status == ST_ALIVE);
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTED)
            $display("ERROR at %0t ns: %s", $time, what);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d, %s: got %0h, expected %0h",
                                      results_seen, name, got, want));
    endtask

    // Offers one item after a random gap and records what it must produce.
    task automatic send_item(input logic [1:0] op, input logic [TIME_W-1:0] stamp);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        @(negedge clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        cmd      = op;
        now_time = stamp;
        do @(posedge clk); while (in_stall);
        tracker_reports.push_back(next_tracker_result(op, stamp));
        items_sent++;
    endtask

    // Stops offering and waits until every owed result has been seen.
    task automatic wait_all_reported();
        @(negedge clk);
        in_valid = 1'b0;
        while (tracker_reports.size() != 0)
            @(posedge clk);
    endtask

    // One register write; every write also restarts tracking in the block.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_MIN_HALF: cfg_min_half   = data;
            REG_MAX_HALF: cfg_max_half   = data;
            REG_GLITCH:   cfg_glitch     = data;
            REG_RECOVERY: cfg_recovery   = data[REC_W-1:0];
            REG_TIMEOUT:  cfg_timeout_ms = data;
            REG_FREQ_ON:  cfg_freq_on    = data[0];
            default: ;
        endcase
        restart_tracking();
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_setting(input logic [15:0] lo, input logic [15:0] hi,
                                 input logic [15:0] glitch, input logic [7:0] rec,
                                 input logic [15:0] tmo_ms, input logic freq_on);
        wait_all_reported();
        write_reg(REG_MIN_HALF, lo);
        write_reg(REG_MAX_HALF, hi);
        write_reg(REG_GLITCH, glitch);
        write_reg(REG_RECOVERY, 16'(rec));
        write_reg(REG_TIMEOUT, tmo_ms);
        write_reg(REG_FREQ_ON, 16'(freq_on));
        settings_used++;
    endtask

    // Mostly plausible mains traffic built around the last accepted edge:
    // good half-cycles, ticks, timeouts, glitches and over-long gaps, with a
    // little clearing, the spare command and pure noise mixed in.
    task automatic offer_random_item();
        int                pick;
        logic [TIME_W-1:0] base;
        logic [TIME_W-1:0] half;
        logic [1:0]        op;
        logic [TIME_W-1:0] stamp;
        base = (prev_edge_stamp != 0) ? prev_edge_stamp : TIME_W'($urandom);
        case ($urandom_range(0, 3))
            0: half = HALF_50_US - 200 + $urandom_range(0, 400);
            1: half = HALF_60_US - 200 + $urandom_range(0, 400);
            2: half = (cfg_min_half < cfg_max_half)
                      ? $urandom_range(cfg_min_half, cfg_max_half) : $urandom_range(0, 65535);
            default: half = FREQ_SPLIT_US - 1 + $urandom_range(0, 2);
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            op    = CMD_EDGE;
            stamp = base + half;
        end else if (pick < 70) begin
            op    = CMD_TICK;
            stamp = base + $urandom_range(0, 20000);
        end else if (pick < 76) begin
            // Silence at or just beyond the timeout, the boundary included.
            op    = CMD_TICK;
            stamp = base + 32'(cfg_timeout_ms) * 32'(US_PER_MS) + $urandom_range(0, 2000);
        end else if (pick < 84) begin
            op    = CMD_EDGE;
            stamp = base + $urandom_range(1, 3000);
        end else if (pick < 90) begin
            op    = CMD_EDGE;
            stamp = base + cfg_max_half + $urandom_range(1, 5000);
        end else if (pick < 92) begin
            op    = CMD_CLEAR;
            stamp = $urandom;
        end else if (pick < 94) begin
            op    = CMD_SPARE;
            stamp = $urandom;
        end else begin
            op    = 2'($urandom_range(0, 3));
            stamp = $urandom;
        end
        send_item(op, stamp);
    endtask

    // Default registers: window edges, the frequency split, unarmed edges,
    // the spare command, the timeout boundary, clearing and time wrap-around.
    task automatic test_directed_window();
        in_gap_max    = STALL_MAX;
        out_stall_max = STALL_MAX;
        send_item(CMD_TICK, 32'd5);
        send_item(CMD_EDGE, 32'd0);
        send_item(CMD_EDGE, 32'd1000);
        send_item(CMD_EDGE, 32'd8000);
        send_item(CMD_EDGE, 32'd20000);
        send_item(CMD_EDGE, 32'd29166);
        send_item(CMD_EDGE, 32'd38331);
        send_item(CMD_EDGE, 32'd45330);
        send_item(CMD_EDGE, 32'd50332);
        send_item(CMD_SPARE, 32'hFFFF_FFFF);
        send_item(CMD_TICK, 32'd138331);
        send_item(CMD_TICK, 32'd138332);
        send_item(CMD_CLEAR, 32'd0);
        // This interval wraps past zero, which leaves the tracker unarmed again.
        send_item(CMD_EDGE, 32'hFFFF_D8F0);
        send_item(CMD_EDGE, 32'd0);
        send_item(CMD_EDGE, 32'd8333);
    endtask

    // Short timeout with classification off: loss, then recovery after
    // the configured number of good edges.
    task automatic test_directed_recovery();
        logic [TIME_W-1:0] t0;
        t0 = 32'h8000_0000;
        apply_setting(RST_MIN_HALF, RST_MAX_HALF, RST_GLITCH, RST_RECOVERY, 16'd5, 1'b0);
        send_item(CMD_EDGE, t0);
        send_item(CMD_EDGE, t0 + 10000);
        send_item(CMD_TICK, t0 + 15001);
        send_item(CMD_EDGE, t0 + 20000);
        send_item(CMD_EDGE, t0 + 30000);
        send_item(CMD_EDGE, t0 + 40000);
    endtask

    // The receiver holds off long enough for the block to fill and stall
    // its input while items keep coming; then the sender waits for all
    // results before going on.
    task automatic test_backpressure();
        apply_setting(16'd7000, 16'd12000, 16'd0, 8'd2, 16'd10, 1'b1);
        in_gap_max      = 0;
        out_stall_max   = 0;
        holdoff_request = HOLDOFF_CYCLES;
        repeat (24) offer_random_item();
        wait_all_reported();
        in_gap_max    = STALL_MAX;
        out_stall_max = STALL_MAX;
        repeat (24) offer_random_item();
    endtask

    // Random traffic under a sequence of register settings.
    task automatic test_setting_sweep();
        int n;
        for (int phase = 0; phase < SWEEP_PHASES; phase++) begin
            n = 90;
            case (phase)
                0: begin
                    apply_setting(16'd7000, 16'd12000, 16'd0, 8'd3, 16'd100, 1'b1);
                    n = 60;
                end
                1: begin
                    apply_setting(16'd7000, 16'd12000, 16'd1500, 8'd2, 16'd8, 1'b1);
                    n = 80;
                end
                2: begin
                    apply_setting(16'd0, 16'd65535, 16'd0, 8'd255, 16'd65535, 1'b1);
                    n = 60;
                end
                3: begin
                    apply_setting(16'd0, 16'd65535, 16'd65535, 8'd1, 16'd0, 1'b0);
                    n = 30;
                end
                4: begin
                    apply_setting(16'd8000, 16'd11000, 16'd0, 8'd1, 16'd1, 1'b1);
                    n = 80;
                end
                5: begin
                    // No recovery count: the register set is invalid.
                    apply_setting(16'd7000, 16'd12000, 16'd0, 8'd0, 16'd100, 1'b1);
                    n = 20;
                end
                6: begin
                    // An empty window is invalid too.
                    apply_setting(16'd12000, 16'd12000, 16'd0, 8'd3, 16'd100, 1'b1);
                    n = 20;
                end
                7: begin
                    apply_setting(16'd65535, 16'd0, 16'd0, 8'd3, 16'd100, 1'b1);
                    n = 10;
                end
                default: begin
                    apply_setting(16'($urandom_range(5000, 8000)),
                                  16'($urandom_range(10500, 14000)),
                                  ($urandom_range(0, 1) != 0) ? 16'($urandom_range(1, 4000))
                                                              : 16'd0,
                                  8'($urandom_range(1, 6)),
                                  16'($urandom_range(1, 12)),
                                  1'($urandom_range(0, 1)));
                end
            endcase
            // Cycle through all four combinations of sender and receiver idling.
            in_gap_max    = (phase % 2 == 1) ? STALL_MAX : 0;
            out_stall_max = ((phase / 2) % 2 == 1) ? STALL_MAX : 0;
            repeat (n) offer_random_item();
        end
    endtask

    // Receiver: stalls for the per-item wait drawn by the checker, or for a
    // whole hold-off stretch when one is requested.
    initial begin
        int holdoff_left;
        holdoff_left = 0;
        out_stall    = 1'b0;
        forever begin
            @(negedge clk);
            if (holdoff_request > 0) begin
                holdoff_left    = holdoff_request;
                holdoff_request = 0;
            end
            if (holdoff_left > 0) begin
                out_stall = 1'b1;
                holdoff_left--;
            end else if (stall_left > 0) begin
                out_stall = 1'b1;
                stall_left--;
            end else begin
                out_stall = 1'b0;
            end
        end
    end

    // Checker: every result taken is matched against the oldest owed one.
    always @(posedge clk) begin
        result_t want;
        if (rst_n && out_valid && !out_stall) begin
            stall_left = $urandom_range(0, out_stall_max);
            results_seen++;
            if (tracker_reports.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with none owed", results_seen));
            end else begin
                want = tracker_reports.pop_front();
                check_field("event_valid", 32'(event_valid), 32'(want.event_valid));
                check_field("event_time", event_time, want.event_time);
                check_field("event_half_cycle", 32'(event_half_cycle),
                            32'(want.interval_us));
                check_field("event_sequence", event_sequence, want.sequence_num);
                check_field("frequency_class", 32'(frequency_class), 32'(want.freq));
                check_field("status_code", 32'(status_code), 32'(want.status));
                check_field("alive", 32'(alive), 32'(want.alive));
            end
        end
    end

    // Watchdog: too many cycles in a row with no handshake on any channel
    // means the block has hung.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: %0d cycles with no item moving", IDLE_LIMIT);
        $display("zero_cross_mains_tracker test failed");
        $finish;
    end

    initial begin
        in_valid  = 1'b0;
        cmd       = CMD_EDGE;
        now_time  = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_MIN_HALF;
        cfg_data  = '0;
        rst_n     = 1'b0;

        // Register values after reset.
        cfg_min_half   = RST_MIN_HALF;
        cfg_max_half   = RST_MAX_HALF;
        cfg_glitch     = RST_GLITCH;
        cfg_recovery   = RST_RECOVERY;
        cfg_timeout_ms = 16'(RST_TIMEOUT_US / US_PER_MS);
        cfg_freq_on    = 1'b1;
        restart_tracking();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_window();
        test_directed_recovery();
        test_backpressure();
        test_setting_sweep();

        // Let any stray result surface before the verdict.
        wait_all_reported();
        repeat (RESULT_LATENCY + 2) @(posedge clk);

        $display("Sent %0d items under %0d register settings, checked %0d results.",
                 items_sent, settings_used, results_seen);
        $display("Saw %0d zero-cross events and %0d loss declarations; %0d mismatches.",
                 event_total, loss_total, error_count);
        if (error_count == 0 && tracker_reports.size() == 0)
            $display("zero_cross_mains_tracker test passed");
        else
            $display("zero_cross_mains_tracker test failed");
        $finish;
    end

endmodule
